/* sv/layer_order_insertion_sorter_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the layer order sorter
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef LAYER_ORDER_INSERTION_SORTER_ASSERT_SVH
`define LAYER_ORDER_INSERTION_SORTER_ASSERT_SVH

`ifndef SYNTHESIS
`define LOR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed: %m");
`define LOR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: %m");
`else
`define LOR_ASSERT(name, clk, rstn, prop)
`define LOR_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

/* sv/lor_pkg.sv */
// ---------------------------------------------------------------------------
// Layer order sorter package
// Record layout, cell control and the sort key shared by the cell chain.
// ---------------------------------------------------------------------------
package lor_pkg;

  localparam int unsigned SceneW = 32;
  localparam int unsigned RoleW  = 8;
  localparam int unsigned ZW     = 32;
  localparam int unsigned NodeW  = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned KeyW   = SceneW + 1 + ZW + NodeW + PosW;

  typedef struct packed {
    logic                 valid;
    logic [SceneW-1:0]    scene_num;
    logic [RoleW-1:0]     role;
    logic signed [ZW-1:0] z_index;
    logic [NodeW-1:0]     node_id;
    logic [PosW-1:0]      position;
  } rec_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

  // The arrival position is the last key, so every key is unique and the
  // order is stable whatever the pass pattern.
  function automatic logic [KeyW-1:0] sort_key(rec_t r, logic [RoleW-1:0] env);
    logic not_env;
    not_env = (r.role != env);
    return {r.scene_num, not_env, ~r.z_index[ZW-1], r.z_index[ZW-2:0], r.node_id,
            r.position};
  endfunction

endpackage

/* sv/layer_order_insertion_sorter.sv */
// ---------------------------------------------------------------------------
// Layer order sorter
// Collects a run of layer records into a chain of cells and sorts them with
// odd-even transposition passes before draining them in order.
// ---------------------------------------------------------------------------
// Records of a run are taken one per cycle and shifted into the cell chain.
// The record marked last_in closes the run: the chain then runs one
// compare-exchange pass per cycle, as many passes as there are stored records,
// and delivers the results one per cycle from the head cell while out_ready_i
// is high, with no input taken during sort and drain.
// Records beyond MAX_ITEMS are dropped and flag overflow on the whole run.
`include "layer_order_insertion_sorter_assert.svh"

module layer_order_insertion_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lor_pkg::RoleW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lor_pkg::SceneW-1:0]        scene_num_i,
  input  logic [lor_pkg::RoleW-1:0]         role_i,
  input  logic signed [lor_pkg::ZW-1:0]     z_index_i,
  input  logic [lor_pkg::NodeW-1:0]         node_id_i,
  input  logic                              last_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lor_pkg::SceneW-1:0]        out_scene_num_o,
  output logic [lor_pkg::RoleW-1:0]         out_role_o,
  output logic signed [lor_pkg::ZW-1:0]     out_z_index_o,
  output logic [lor_pkg::NodeW-1:0]         out_node_id_o,
  output logic [lor_pkg::PosW-1:0]          arrival_position_o,
  output logic                              last_out_o,
  output logic                              overflow_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_e;

  state_e              state_d, state_q;
  logic [CntW-1:0]     fill_d, fill_q;
  logic [CntW-1:0]     phase_d, phase_q;
  logic                ovf_d, ovf_q;
  logic [lor_pkg::RoleW-1:0] env_q;

  logic load_shift, drain_shift, sorting;

  lor_pkg::rec_t      new_rec;
  lor_pkg::rec_t      empty_rec;
  lor_pkg::rec_t      cells[MAX_ITEMS];
  lor_pkg::cell_ctrl_t ctrl[MAX_ITEMS];
  logic               swap[MAX_ITEMS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (cfg_we_i) begin
      env_q <= cfg_data_i;
    end
  end

  always_comb begin
    new_rec.valid     = 1'b1;
    new_rec.scene_num = scene_num_i;
    new_rec.role      = role_i;
    new_rec.z_index   = z_index_i;
    new_rec.node_id   = node_id_i;
    new_rec.position  = lor_pkg::PosW'(fill_q);
  end

  assign empty_rec = '0;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    phase_d     = phase_q;
    ovf_d       = ovf_q;
    load_shift  = 1'b0;
    drain_shift = 1'b0;
    sorting     = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          if (fill_q < CntW'(MAX_ITEMS)) begin
            load_shift = 1'b1;
            fill_d     = fill_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_in_i) begin
            phase_d = '0;
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        sorting = 1'b1;
        phase_d = phase_q + CntW'(1);
        if (phase_q == fill_q - CntW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_ready_i) begin
          drain_shift = 1'b1;
          if (last_out_o) begin
            state_d = ST_LOAD;
            fill_d  = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      phase_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS - 1; i++) begin : g_cmp
    lor_cmp u_cmp (
      .lower_i (cells[i]),
      .upper_i (cells[i+1]),
      .env_i   (env_q),
      .swap_o  (swap[i])
    );
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    lor_pkg::rec_t left_rec, right_rec;
    logic          pair_up, pair_dn;

    if (i == 0) begin : g_head
      assign left_rec = new_rec;
      assign pair_dn  = 1'b0;
    end else begin : g_body
      assign left_rec = cells[i-1];
      assign pair_dn  = (1'((i - 1) % 2) == phase_q[0]) && swap[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_rec = empty_rec;
      assign pair_up   = 1'b0;
    end else begin : g_inner
      assign right_rec = cells[i+1];
      assign pair_up   = (1'(i % 2) == phase_q[0]) && swap[i];
    end

    assign ctrl[i].take_left  = load_shift || (sorting && pair_dn);
    assign ctrl[i].take_right = drain_shift || (sorting && pair_up);

    lor_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[i]),
      .left_i  (left_rec),
      .right_i (right_rec),
      .rec_o   (cells[i])
    );
  end

  assign in_ready_o         = (state_q == ST_LOAD);
  assign out_valid_o        = (state_q == ST_DRAIN);
  assign out_scene_num_o    = cells[0].scene_num;
  assign out_role_o         = cells[0].role;
  assign out_z_index_o      = cells[0].z_index;
  assign out_node_id_o      = cells[0].node_id;
  assign arrival_position_o = cells[0].position;
  assign last_out_o         = !cells[1].valid;
  assign overflow_o         = ovf_q;

  `LOR_ASSERT(a_one_side, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `LOR_ASSERT(a_head_valid, clk_i, rst_ni, out_valid_o |-> cells[0].valid)
  `LOR_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= CntW'(MAX_ITEMS))
  `LOR_ASSERT(a_phase_bound, clk_i, rst_ni, (state_q == ST_SORT) |-> (phase_q < fill_q))
  `LOR_ASSERT(a_run_end, clk_i, rst_ni,
              (out_valid_o && out_ready_i && last_out_o) |=> (in_ready_o && fill_q == '0))

endmodule

/* sv/lor_cell.sv */
// ---------------------------------------------------------------------------
// Sorter cell
// Holds one record and takes its neighbor's record on command.
// ---------------------------------------------------------------------------
module lor_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lor_pkg::cell_ctrl_t ctrl_i,
  input  lor_pkg::rec_t       left_i,
  input  lor_pkg::rec_t       right_i,
  output lor_pkg::rec_t       rec_o
);

  lor_pkg::rec_t rec_d, rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.take_left) begin
      rec_d = left_i;
    end else if (ctrl_i.take_right) begin
      rec_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

/* sv/lor_cmp.sv */
// ---------------------------------------------------------------------------
// Sorter compare-exchange
// Decides whether two neighboring cells swap their records in a pass.
// ---------------------------------------------------------------------------
module lor_cmp (
  input  lor_pkg::rec_t                lower_i,
  input  lor_pkg::rec_t                upper_i,
  input  logic [lor_pkg::RoleW-1:0]    env_i,
  output logic                         swap_o
);

  logic [lor_pkg::KeyW-1:0] key_lo, key_up;

  assign key_lo = lor_pkg::sort_key(lower_i, env_i);
  assign key_up = lor_pkg::sort_key(upper_i, env_i);
  assign swap_o = upper_i.valid && (!lower_i.valid || (key_up < key_lo));

endmodule
